### rtl/pvms_pkg.sv
// ----------------------------------------------------------------------------
// pvms_pkg
// Shared types, widths and constants of the proximity steering unit.
// ----------------------------------------------------------------------------
package pvms_pkg;

  localparam int NUM_SENSORS  = 8;
  localparam int PROX_W       = 12;
  localparam int SPD_W        = 8;
  localparam int OUT_W        = 10;
  localparam int X_W          = 10;   // x lies in -176..332
  localparam int Y_W          = 9;    // y lies in -250..250
  localparam int LEN_W        = 9;    // floor sqrt of x*x + y*y, at most 415
  localparam int WEIGHT_W     = 7;
  localparam int TERM_W       = 8;    // signed projection term, -100..100
  localparam int WEIGHT_LIMIT = 100;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 24;

  localparam int MODE_W  = 4;
  localparam int MS_W    = 8;
  localparam int CD_W    = 9;
  localparam int THR_W   = 9;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DISTANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEEN_THRESHOLD = 2'd3;

  localparam logic [MODE_W-1:0] MODE_STOP = 4'd0;
  localparam int MODE_CHASE_BIT = 3;   // modes 8..15 chase

  localparam logic [MODE_W-1:0] RST_MODE           = 4'd0;
  localparam logic [MS_W-1:0]   RST_SPEED_SCALE    = 8'd128;
  localparam logic [CD_W-1:0]   RST_CLOSE_DISTANCE = 9'd200;
  localparam logic [THR_W-1:0]  RST_SEEN_THRESHOLD = 9'd25;

  // direction coefficients per sensor
  localparam int DIR_X [NUM_SENSORS] = '{96, 70, 0, -88, -88, 0, 70, 96};
  localparam int DIR_Y [NUM_SENSORS] = '{30, 72, 100, 48, -48, -100, -72, -30};

  // v / 100 as (v * MUL) >> SHIFT; small form is exact for v <= 10000,
  // wide form for v <= 25500
  localparam int DIV100_SMALL_MUL   = 5243;
  localparam int DIV100_SMALL_SHIFT = 19;
  localparam int DIV100_MUL         = 41944;
  localparam int DIV100_SHIFT       = 22;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic [SPD_W-1:0]      dl;
    logic [SPD_W-1:0]      dr;
  } vec_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MS_W-1:0]   speed_scale;
    logic [CD_W-1:0]   close_distance;
    logic [THR_W-1:0]  seen_threshold;
  } cfg_t;

endpackage

### rtl/pvms_div.sv
// ----------------------------------------------------------------------------
// pvms_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pvms_div #(
  parameter int DW = 9,
  parameter int QW = 8
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  localparam int W = DW + QW;

  logic [W-1:0]  work  [1:QW];
  logic [DW-1:0] dpipe [1:QW-1];

  // shift one numerator bit into the partial remainder, subtract if it fits
  function automatic logic [W-1:0] step(input logic [W-1:0] w, input logic [DW-1:0] d);
    logic [DW:0] t;
    logic        ge;
    logic [DW:0] r;
    t  = {w[W-1:QW], w[QW-1]};
    ge = (t >= {1'b0, d});
    r  = ge ? (t - {1'b0, d}) : t;
    return {r[DW-1:0], w[QW-2:0], ge};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      work[1]  <= step(num, den);
      dpipe[1] <= den;
      for (int j = 2; j <= QW; j++) begin
        work[j] <= step(work[j-1], dpipe[j-1]);
      end
      for (int j = 2; j < QW; j++) begin
        dpipe[j] <= dpipe[j-1];
      end
    end
  end

  assign quo = work[QW][QW-1:0];

endmodule

### rtl/pvms_front.sv
// ----------------------------------------------------------------------------
// pvms_front
// Accepts sensor frames, turns readings into weights and sums the vector.
// ----------------------------------------------------------------------------
module pvms_front #(
  parameter int DEPTH = 4,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pvms_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [CNT_W-1:0]               queue_count,
  output logic                           push,
  output pvms_pkg::vec_t                 push_data
);
  import pvms_pkg::*;

  logic                     f_valid;
  logic signed [TERM_W-1:0] tx [NUM_SENSORS];
  logic signed [TERM_W-1:0] ty [NUM_SENSORS];
  logic [SPD_W-1:0]         dl;
  logic [SPD_W-1:0]         dr;
  logic signed [X_W-1:0]    x_sum;
  logic signed [Y_W-1:0]    y_sum;
  logic                     accept;

  // truncated (w * coef) / 100, sign of coef applied to the magnitude
  function automatic logic signed [TERM_W-1:0] term(input logic [WEIGHT_W-1:0] w,
                                                    input int coef);
    logic [26:0]         p;
    logic [WEIGHT_W-1:0] m;
    p = 27'(w) * 27'((coef < 0) ? -coef : coef) * 27'(DIV100_SMALL_MUL);
    m = p[DIV100_SMALL_SHIFT +: WEIGHT_W];
    return (coef < 0) ? -TERM_W'(m) : TERM_W'(m);
  endfunction

  // leave room for the item already in the term stage
  assign s_axis_tready = ((CNT_W+1)'(queue_count) + (CNT_W+1)'(f_valid))
                         < (CNT_W+1)'(DEPTH);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    logic [PROX_W-1:0]   r;
    logic [WEIGHT_W-1:0] w;
    if (accept) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        r = s_axis_tdata[i*PROX_W +: PROX_W];
        w = (r > PROX_W'(WEIGHT_LIMIT)) ? '0 : WEIGHT_W'(PROX_W'(WEIGHT_LIMIT) - r);
        tx[i] <= term(w, DIR_X[i]);
        ty[i] <= term(w, DIR_Y[i]);
      end
      dl <= s_axis_tdata[NUM_SENSORS*PROX_W +: SPD_W];
      dr <= s_axis_tdata[NUM_SENSORS*PROX_W+SPD_W +: SPD_W];
    end
  end

  always_comb begin
    x_sum = '0;
    y_sum = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      x_sum = x_sum + X_W'(tx[i]);
      y_sum = y_sum + Y_W'(ty[i]);
    end
  end

  assign push         = f_valid;
  assign push_data.x  = x_sum;
  assign push_data.y  = y_sum;
  assign push_data.dl = dl;
  assign push_data.dr = dr;

endmodule

### rtl/pvms_queue.sv
// ----------------------------------------------------------------------------
// pvms_queue
// Small FIFO of vectors between the front and the back.
// ----------------------------------------------------------------------------
module pvms_queue #(
  parameter int DEPTH = 4,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pvms_pkg::vec_t   push_data,
  input  logic             pop,
  output pvms_pkg::vec_t   pop_data,
  output logic             not_empty,
  output logic [CNT_W-1:0] count
);
  import pvms_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign pop_data  = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

### rtl/pvms_back.sv
// ----------------------------------------------------------------------------
// pvms_back
// Vector length, scaled sine and cosine, steering and mode selection.
// ----------------------------------------------------------------------------
module pvms_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  pvms_pkg::vec_t                  in_data,
  output logic                            pop,
  input  pvms_pkg::cfg_t                  cfg,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pvms_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pvms_pkg::*;

  localparam int SQ_STEPS = LEN_W;
  localparam int Q1 = 7;           // quotient of |x|*100 / len is at most 100
  localparam int Q2 = 8;           // steering quotient is below 256
  localparam int N1 = LEN_W + Q1;
  localparam int N2 = CD_W + Q2;
  localparam int SQ_W = 2 * LEN_W;
  localparam int REM_W = LEN_W + 3;
  localparam int MAG_W = 8;
  localparam int P_W = 15;
  localparam int R_W = 31;
  localparam int LAT = 2 + SQ_STEPS + Q1 + 4 + Q2 + 1;
  localparam int AW = 11;          // steering arithmetic width

  typedef struct packed {
    vec_t             v;
    logic [LEN_W-1:0] len;
  } ctx_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [LEN_W-1:0] root;
  } sq_t;

  logic           en;
  logic [LAT-1:0] vld;

  // S1
  vec_t          s1_v;
  logic [16:0]   s1_xx;
  logic [15:0]   s1_yy;
  // square root chain
  logic [SQ_W-1:0]  sq_val  [0:SQ_STEPS];
  sq_t              sq_st   [0:SQ_STEPS];
  vec_t             sq_v    [0:SQ_STEPS];
  // first divide
  ctx_t             d1_ctx  [0:Q1-1];
  logic [Q1-1:0]    qx;
  logic [Q1-1:0]    qy;
  logic [N1-1:0]    nx;
  logic [N1-1:0]    ny;
  // scale and reciprocal stages
  ctx_t             m_ctx;
  logic [P_W-1:0]   m_px;
  logic [P_W-1:0]   m_py;
  ctx_t             p_ctx;
  logic [R_W-1:0]   p_cx;
  logic [R_W-1:0]   p_cy;
  ctx_t             cs_ctx;
  logic [MAG_W-1:0] cs_cmag;
  logic [MAG_W-1:0] cs_smag;
  ctx_t             tn_ctx;
  logic [MAG_W-1:0] tn_cmag;
  logic [MAG_W-1:0] tn_smag;
  logic [N2-1:0]    tn_num;
  // second divide
  ctx_t             d2_ctx  [0:Q2-1];
  logic [MAG_W-1:0] d2_cmag [0:Q2-1];
  logic [MAG_W-1:0] d2_smag [0:Q2-1];
  logic [Q2-1:0]    q2;

  logic [X_W-1:0]   ax_full;
  logic [Y_W-1:0]   ay_full;
  logic [X_W-1:0]   ax9_full;
  logic [Y_W-1:0]   ay9_full;

  function automatic sq_t sqrt_step(input sq_t st, input logic [1:0] pair);
    logic [REM_W-1:0] rem_n;
    logic [REM_W-1:0] trial;
    sq_t              r;
    rem_n = {st.rem[REM_W-3:0], pair};
    trial = REM_W'({st.root, 2'b01});
    if (rem_n >= trial) begin
      r.rem  = rem_n - trial;
      r.root = {st.root[LEN_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_n;
      r.root = {st.root[LEN_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // hold everything while a finished item waits at the output
  assign en  = !vld[LAT-1] || m_axis_tready;
  assign pop = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pop};
    end
  end

  assign ax_full = in_data.x[X_W-1] ? -in_data.x : in_data.x;
  assign ay_full = in_data.y[Y_W-1] ? -in_data.y : in_data.y;

  // S1 squares, S2 sum, then one root bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      s1_v  <= in_data;
      s1_xx <= 17'(ax_full[X_W-2:0]) * 17'(ax_full[X_W-2:0]);
      s1_yy <= 16'(ay_full[Y_W-2:0]) * 16'(ay_full[Y_W-2:0]);
      sq_val[0] <= SQ_W'(s1_xx) + SQ_W'(s1_yy);
      sq_st[0]  <= '0;
      sq_v[0]   <= s1_v;
      for (int k = 1; k <= SQ_STEPS; k++) begin
        sq_val[k] <= sq_val[k-1] << 2;
        sq_st[k]  <= sqrt_step(sq_st[k-1], sq_val[k-1][SQ_W-1 -: 2]);
        sq_v[k]   <= sq_v[k-1];
      end
    end
  end

  assign ax9_full = sq_v[SQ_STEPS].x[X_W-1] ? -sq_v[SQ_STEPS].x : sq_v[SQ_STEPS].x;
  assign ay9_full = sq_v[SQ_STEPS].y[Y_W-1] ? -sq_v[SQ_STEPS].y : sq_v[SQ_STEPS].y;
  assign nx = N1'(ax9_full) * N1'(WEIGHT_LIMIT);
  assign ny = N1'(ay9_full) * N1'(WEIGHT_LIMIT);

  pvms_div #(.DW(LEN_W), .QW(Q1)) u_div_x (
    .clk (clk), .en (en), .num (nx), .den (sq_st[SQ_STEPS].root), .quo (qx)
  );

  pvms_div #(.DW(LEN_W), .QW(Q1)) u_div_y (
    .clk (clk), .en (en), .num (ny), .den (sq_st[SQ_STEPS].root), .quo (qy)
  );

  always_ff @(posedge clk) begin
    logic             x_pos;
    logic [X_W:0]     gap;
    if (en) begin
      d1_ctx[0].v   <= sq_v[SQ_STEPS];
      d1_ctx[0].len <= sq_st[SQ_STEPS].root;
      for (int j = 1; j < Q1; j++) begin
        d1_ctx[j] <= d1_ctx[j-1];
      end
      // scale by the speed scale register
      m_ctx <= d1_ctx[Q1-1];
      m_px  <= P_W'(qx) * P_W'(cfg.speed_scale);
      m_py  <= P_W'(qy) * P_W'(cfg.speed_scale);
      // divide by 100 through the reciprocal
      p_ctx <= m_ctx;
      p_cx  <= R_W'(m_px) * R_W'(DIV100_MUL);
      p_cy  <= R_W'(m_py) * R_W'(DIV100_MUL);
      // zero length gives no angle
      cs_ctx  <= p_ctx;
      cs_cmag <= (p_ctx.len == '0) ? '0 : p_cx[DIV100_SHIFT +: MAG_W];
      cs_smag <= (p_ctx.len == '0) ? '0 : p_cy[DIV100_SHIFT +: MAG_W];
      // forward term numerator, only between zero and the close distance
      x_pos = !cs_ctx.v.x[X_W-1] && (cs_ctx.v.x != '0);
      gap   = (X_W+1)'(cfg.close_distance) - (X_W+1)'(cs_ctx.v.x);
      tn_ctx  <= cs_ctx;
      tn_cmag <= cs_cmag;
      tn_smag <= cs_smag;
      tn_num  <= (x_pos && !gap[X_W] && gap != '0)
                 ? N2'(cs_cmag) * N2'(gap[CD_W-1:0]) : '0;
      d2_ctx[0]  <= tn_ctx;
      d2_cmag[0] <= tn_cmag;
      d2_smag[0] <= tn_smag;
      for (int j = 1; j < Q2; j++) begin
        d2_ctx[j]  <= d2_ctx[j-1];
        d2_cmag[j] <= d2_cmag[j-1];
        d2_smag[j] <= d2_smag[j-1];
      end
    end
  end

  pvms_div #(.DW(CD_W), .QW(Q2)) u_div_t (
    .clk (clk), .en (en), .num (tn_num), .den (cfg.close_distance), .quo (q2)
  );

  always_ff @(posedge clk) begin
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] c;
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] l;
    logic signed [AW-1:0] r;
    logic                 seen;
    ctx_t                 k;
    k = d2_ctx[Q2-1];
    x = AW'(k.v.x);
    c = k.v.x[X_W-1] ? -AW'(d2_cmag[Q2-1]) : AW'(d2_cmag[Q2-1]);
    s = k.v.y[Y_W-1] ? -AW'(d2_smag[Q2-1]) : AW'(d2_smag[Q2-1]);
    t = -AW'(q2);
    seen = (k.len >= cfg.seen_threshold);
    if (x > 0) begin
      if (x >= AW'(cfg.close_distance)) begin
        l = -s;
        r = s;
      end else begin
        l = t - s;
        r = t + s;
      end
    end else begin
      l = -c - s;
      r = -c + s;
    end
    if (cfg.mode == MODE_STOP) begin
      l = '0;
      r = '0;
    end else if (!cfg.mode[MODE_CHASE_BIT]) begin
      if (!seen) begin
        l = AW'(k.v.dl);
        r = AW'(k.v.dr);
      end
    end else begin
      if (!seen) begin
        l = '0;
        r = '0;
      end else begin
        l = -l;
        r = -r;
      end
    end
    if (en) begin
      m_axis_tdata <= {(OUT_DATA_W-2*OUT_W)'(0), r[OUT_W-1:0], l[OUT_W-1:0]};
    end
  end

  assign m_axis_tvalid = vld[LAT-1];

endmodule

### rtl/proximity_vector_motor_steering_unit.sv
// ----------------------------------------------------------------------------
// proximity_vector_motor_steering_unit
// Turns eight proximity readings into left and right wheel speeds.
// ----------------------------------------------------------------------------
// channel   | dir | payload
// s_axis    | in  | prox_0..prox_7 (12b each), default_left/right_speed (8b)
// m_axis    | out | left_speed, right_speed (10b signed each)
// cfg       | in  | mode, speed scale, close_distance, seen_threshold
//
// One item per cycle sustained while the output is not stalled; m_axis_tvalid
// rises once the item has passed the term stage, the queue and the 31 back
// stages, whose number is set by the root stages and the two dividers.
// Synchronous reset clears the queue, the valid chains and the cfg registers.
// A stalled output holds the whole back pipeline; the queue absorbs the front.
// ----------------------------------------------------------------------------
module proximity_vector_motor_steering_unit #(
  parameter int QUEUE_DEPTH = pvms_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // prox_0..prox_7, default_left_speed, default_right_speed
  input  logic [pvms_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // left_speed, right_speed, zero fill
  output logic [pvms_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_wen,
  input  logic [pvms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pvms_pkg::CFG_W-1:0]      cfg_wdata
);
  import pvms_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t             cfg;
  logic             push;
  vec_t             push_data;
  logic             pop;
  vec_t             pop_data;
  logic             not_empty;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= RST_MODE;
      cfg.speed_scale    <= RST_SPEED_SCALE;
      cfg.close_distance <= RST_CLOSE_DISTANCE;
      cfg.seen_threshold <= RST_SEEN_THRESHOLD;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_MODE:           cfg.mode           <= cfg_wdata[MODE_W-1:0];
        REG_SPEED_SCALE:    cfg.speed_scale    <= cfg_wdata[MS_W-1:0];
        REG_CLOSE_DISTANCE: cfg.close_distance <= cfg_wdata[CD_W-1:0];
        REG_SEEN_THRESHOLD: cfg.seen_threshold <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  pvms_front #(.DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .queue_count   (count),
    .push          (push),
    .push_data     (push_data)
  );

  pvms_queue #(.DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty),
    .count     (count)
  );

  pvms_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (not_empty),
    .in_data       (pop_data),
    .pop           (pop),
    .cfg           (cfg),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### rtl/pvms_check.sv
// ----------------------------------------------------------------------------
// pvms_check
// Port-level checks of the steering unit, bound to the top level.
// ----------------------------------------------------------------------------
module pvms_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pvms_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pvms_pkg::*;

  // nothing may come out right after reset: the pipeline is empty
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // speeds never exceed 510 in magnitude
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9:0] != 10'h200) && (m_axis_tdata[9:0] != 10'h201)
                      && (m_axis_tdata[9:0] != 10'h1FF))
    else $error("left speed out of range");

  a_right_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[19:10] != 10'h200) && (m_axis_tdata[19:10] != 10'h201)
                      && (m_axis_tdata[19:10] != 10'h1FF) && (m_axis_tdata[23:20] == 4'h0))
    else $error("right speed out of range or fill bits set");

endmodule

bind proximity_vector_motor_steering_unit pvms_check u_pvms_check (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
